// ----- sv/hcbd_pkg.sv -----
// hcbd_pkg: shared types, constants and helpers for the chunked body decoder
// no dependencies; imported by the config interface, the core and the bench

package hcbd_pkg;

    localparam int SIZE_BITS = 32;
    localparam int CMP_W     = ((SIZE_BITS > 32) ? SIZE_BITS : 32) + 1;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE  = CFG_IDX_W'(1);

    typedef logic [SIZE_BITS-1:0] t_size;
    typedef logic [SIZE_BITS:0]   t_size_sum;
    typedef logic [CMP_W-1:0]     t_cmp;

    typedef enum logic [2:0] {
        PH_SIZE     = 3'd0,
        PH_SIZE_LF  = 3'd1,
        PH_DATA     = 3'd2,
        PH_TRAIL_CR = 3'd3,
        PH_TRAIL_LF = 3'd4,
        PH_DONE     = 3'd5,
        PH_ERROR    = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_LINE  = 2'd1,
        ERR_LIMIT = 2'd2,
        ERR_CRLF  = 2'd3
    } t_err;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.val = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            h.val = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- sv/hcbd_if.sv -----
// hcbd_if: valid/ready channel interfaces for input bytes, decoded results and config
// depends on hcbd_pkg for the config port widths

interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] byte_in;
    modport source (output valid, output mode, output byte_in, input ready);
    modport sink   (input valid, input mode, input byte_in, output ready);
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic       body_valid;
    logic [7:0] body_byte;
    logic       done_res;
    logic       failed;
    logic [1:0] error_kind;
    modport source (output valid, output body_valid, output body_byte, output done_res,
                    output failed, output error_kind, input ready);
    modport sink   (input valid, input body_valid, input body_byte, input done_res,
                    input failed, input error_kind, output ready);
endinterface

interface hcbd_cfg_if;
    import hcbd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/http_chunked_body_decoder_core.sv -----
// http_chunked_body_decoder_core: byte-serial HTTP/1.1 chunked body decoder
// depends on hcbd_pkg and the channel interfaces in hcbd_if.sv
//
//   channel  dir  word                                      accepted when
//   i_in     in   mode, byte_in                              valid && ready
//   o_out    out  body_valid, body_byte, done_res,
//                 failed, error_kind                         valid && ready
//   i_cfg    in   index, data (0 max_body_size, 1 limit_en)  valid && ready (ready always 1)
//
// one byte per clock unless the result stalls: the decode is one pass of logic from the
// parser state and the incoming byte into a single result register.
// the input is taken whenever the result register is empty or being drained.
// synchronous active-low reset clears the parser state, config and output valid.
// a stalled result holds the input back; nothing else stalls.

module http_chunked_body_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcbd_in_if.sink    i_in,
    hcbd_out_if.source o_out,
    hcbd_cfg_if.sink   i_cfg
);
    import hcbd_pkg::*;

    // config
    logic [31:0] r_max_body;
    logic        r_limit_en;

    // parser state
    t_phase     r_phase,      n_phase;
    t_size      r_size_accum, n_size_accum;
    logic [3:0] r_digit_cnt,  n_digit_cnt;
    t_size      r_bytes_left, n_bytes_left;
    logic       r_last_chunk, n_last_chunk;
    t_size      r_body_total, n_body_total;
    t_err       r_err,        n_err;

    // result register
    logic       r_out_valid;
    logic       r_body_valid, n_body_valid;
    logic [7:0] r_body_byte,  n_body_byte;

    logic      in_acc;
    t_hex      hex;
    t_size_sum sum;
    logic      over_limit;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign hex = hex_decode(i_in.byte_in);
    assign sum = t_size_sum'(r_body_total) + t_size_sum'(r_size_accum);
    // total plus new chunk above the limit, compared wide so nothing wraps
    assign over_limit = (t_cmp'(sum) > t_cmp'(r_max_body));

    always_comb begin
        n_phase      = r_phase;
        n_size_accum = r_size_accum;
        n_digit_cnt  = r_digit_cnt;
        n_bytes_left = r_bytes_left;
        n_last_chunk = r_last_chunk;
        n_body_total = r_body_total;
        n_err        = r_err;
        n_body_valid = 1'b0;
        n_body_byte  = 8'd0;
        if (i_in.mode) begin
            n_phase      = PH_SIZE;
            n_size_accum = '0;
            n_digit_cnt  = 4'd0;
            n_bytes_left = '0;
            n_last_chunk = 1'b0;
            n_body_total = '0;
            n_err        = ERR_NONE;
        end else begin
            case (r_phase)
                PH_SIZE: begin
                    if (i_in.byte_in == CHAR_CR) begin
                        if (r_digit_cnt == 4'd0) begin
                            n_phase = PH_ERROR;
                            n_err   = ERR_LINE;
                        end else begin
                            n_phase = PH_SIZE_LF;
                        end
                    end else if (!hex.ok || (r_size_accum[SIZE_BITS-1 -: 4] != 4'd0)) begin
                        n_phase = PH_ERROR;
                        n_err   = ERR_LINE;
                    end else begin
                        n_size_accum = {r_size_accum[SIZE_BITS-5:0], hex.val};
                        if (r_digit_cnt != 4'hF) begin
                            n_digit_cnt = r_digit_cnt + 4'd1;
                        end
                    end
                end
                PH_SIZE_LF: begin
                    if (i_in.byte_in != CHAR_LF) begin
                        n_phase = PH_ERROR;
                        n_err   = ERR_LINE;
                    end else if ((r_size_accum != '0) && r_limit_en && over_limit) begin
                        n_phase = PH_ERROR;
                        n_err   = ERR_LIMIT;
                    end else begin
                        // saturate the running total on carry out
                        n_body_total = sum[SIZE_BITS] ? '1 : sum[SIZE_BITS-1:0];
                        n_bytes_left = r_size_accum;
                        n_size_accum = '0;
                        n_digit_cnt  = 4'd0;
                        if (r_size_accum == '0) begin
                            n_last_chunk = 1'b1;
                            n_phase      = PH_TRAIL_CR;
                        end else begin
                            n_last_chunk = 1'b0;
                            n_phase      = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_body_valid = 1'b1;
                    n_body_byte  = i_in.byte_in;
                    n_bytes_left = r_bytes_left - t_size'(1);
                    if (r_bytes_left == t_size'(1)) begin
                        n_phase = PH_TRAIL_CR;
                    end
                end
                PH_TRAIL_CR: begin
                    if (i_in.byte_in == CHAR_CR) begin
                        n_phase = PH_TRAIL_LF;
                    end else begin
                        n_phase = PH_ERROR;
                        n_err   = ERR_CRLF;
                    end
                end
                PH_TRAIL_LF: begin
                    if (i_in.byte_in != CHAR_LF) begin
                        n_phase = PH_ERROR;
                        n_err   = ERR_CRLF;
                    end else if (r_last_chunk) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_SIZE;
                    end
                end
                PH_DONE, PH_ERROR: begin
                end
                default: begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_LINE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body   <= 32'd0;
            r_limit_en   <= 1'b0;
            r_phase      <= PH_SIZE;
            r_size_accum <= '0;
            r_digit_cnt  <= 4'd0;
            r_bytes_left <= '0;
            r_last_chunk <= 1'b0;
            r_body_total <= '0;
            r_err        <= ERR_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_MAX_BODY_SIZE) begin
                    r_max_body <= i_cfg.data;
                end else if (i_cfg.index == REG_LIMIT_ENABLE) begin
                    r_limit_en <= i_cfg.data[0];
                end
            end
            if (in_acc) begin
                r_phase      <= n_phase;
                r_size_accum <= n_size_accum;
                r_digit_cnt  <= n_digit_cnt;
                r_bytes_left <= n_bytes_left;
                r_last_chunk <= n_last_chunk;
                r_body_total <= n_body_total;
                r_err        <= n_err;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_body_valid <= n_body_valid;
            r_body_byte  <= n_body_byte;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.body_valid = r_body_valid;
    assign o_out.body_byte  = r_body_byte;
    assign o_out.done_res   = (r_phase == PH_DONE);
    assign o_out.failed     = (r_phase == PH_ERROR);
    assign o_out.error_kind = r_err;

    // a data phase always has bytes still to come
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bytes_left != '0))
        else $error("data phase with no bytes left");

    // the error code is set exactly when the decoder sits in its error state
    a_err_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.failed == (o_out.error_kind != ERR_NONE)))
        else $error("failed flag and error kind disagree");

    // a passed-through byte never comes with done or failed
    a_body_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.body_valid) |-> (!o_out.done_res && !o_out.failed))
        else $error("body byte alongside done or failed");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking bench for http_chunked_body_decoder_core, byte stream in, one word out
// depends on hcbd_pkg, the channel interfaces in hcbd_if.sv and the core itself

module tb;
    import hcbd_pkg::*;

    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_RESTART = 1'b1;
    localparam int   IDLE_LIMIT   = 2000;
    localparam int   TOTAL_ITEMS  = 1450;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic       done_res;
        logic       failed;
        logic [1:0] error_kind;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hcbd_in_if  in_ch ();
    hcbd_out_if out_ch ();
    hcbd_cfg_if cfg_ch ();

    http_chunked_body_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #10 i_clk = ~i_clk;

    // decoder state as the bench sees it
    t_phase      dec_phase;
    t_size       dec_accum;
    logic [3:0]  dec_digits;
    t_size       dec_left;
    logic        dec_last;
    t_size       dec_total;
    t_err        dec_err;
    logic [31:0] lim_max;
    logic        lim_en;

    t_word       decoded_q[$];
    logic [8:0]  msg_q[$];
    int          errors = 0;
    int          sent = 0;
    int          idle_cycles = 0;
    bit          gaps_on = 1'b1;
    bit          quiet = 1'b0;

    function automatic int nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            return int'(c - "a") + 10;
        end else if (c >= "A" && c <= "F") begin
            return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    function automatic void clear_decoder();
        dec_phase  = PH_SIZE;
        dec_accum  = '0;
        dec_digits = '0;
        dec_left   = '0;
        dec_last   = 1'b0;
        dec_total  = '0;
        dec_err    = ERR_NONE;
    endfunction

    function automatic void decoder_fail(t_err kind);
        dec_phase = PH_ERROR;
        dec_err   = kind;
    endfunction

    // end of a size line: limit check, then start the chunk
    function automatic void open_chunk();
        t_size              sz;
        logic [SIZE_BITS:0] sum;
        sz = dec_accum;
        if (sz != '0 && lim_en) begin
            if (64'(dec_total) > 64'(lim_max) || 64'(sz) > 64'(lim_max) - 64'(dec_total)) begin
                decoder_fail(ERR_LIMIT);
                return;
            end
        end
        sum = {1'b0, dec_total} + {1'b0, sz};
        dec_total  = sum[SIZE_BITS] ? '1 : sum[SIZE_BITS-1:0];
        dec_left   = sz;
        dec_accum  = '0;
        dec_digits = '0;
        dec_last   = (sz == '0);
        dec_phase  = (sz == '0) ? PH_TRAIL_CR : PH_DATA;
    endfunction

    function automatic t_word decode_byte(logic m, logic [7:0] c);
        t_word w;
        int    d;
        w = '0;
        if (m == MODE_RESTART) begin
            clear_decoder();
        end else begin
            case (dec_phase)
                PH_SIZE: begin
                    if (c == CHAR_CR) begin
                        if (dec_digits == '0) decoder_fail(ERR_LINE);
                        else dec_phase = PH_SIZE_LF;
                    end else begin
                        d = nibble_of(c);
                        // a digit that would push bits past the top is a bad line
                        if (d < 0 || dec_accum[SIZE_BITS-1 -: 4] != '0) begin
                            decoder_fail(ERR_LINE);
                        end else begin
                            dec_accum = {dec_accum[SIZE_BITS-5:0], 4'(d)};
                            if (dec_digits != 4'd15) dec_digits = dec_digits + 4'd1;
                        end
                    end
                end
                PH_SIZE_LF: begin
                    if (c == CHAR_LF) open_chunk();
                    else decoder_fail(ERR_LINE);
                end
                PH_DATA: begin
                    w.body_valid = 1'b1;
                    w.body_byte  = c;
                    if (dec_left != '0) dec_left = dec_left - 1'b1;
                    if (dec_left == '0) dec_phase = PH_TRAIL_CR;
                end
                PH_TRAIL_CR: begin
                    if (c == CHAR_CR) dec_phase = PH_TRAIL_LF;
                    else decoder_fail(ERR_CRLF);
                end
                PH_TRAIL_LF: begin
                    if (c != CHAR_LF) decoder_fail(ERR_CRLF);
                    else if (dec_last) dec_phase = PH_DONE;
                    else dec_phase = PH_SIZE;
                end
                default: ;
            endcase
        end
        w.done_res   = (dec_phase == PH_DONE);
        w.failed     = (dec_phase == PH_ERROR);
        w.error_kind = dec_err;
        return w;
    endfunction

    task automatic send_item(logic m, logic [7:0] c);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= m;
        in_ch.byte_in <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        decoded_q.push_back(decode_byte(m, c));
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(MODE_BYTE, s[i]);
    endtask

    task automatic restart();
        send_item(MODE_RESTART, 8'($urandom));
    endtask

    // stop sending and let every outstanding word come back
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == REG_MAX_BODY_SIZE) lim_max = val;
        else if (idx == REG_LIMIT_ENABLE) lim_en = val[0];
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_limit(logic [31:0] max_size, logic en);
        drain();
        write_reg(REG_MAX_BODY_SIZE, max_size);
        // upper bits of the enable word are junk on purpose
        write_reg(REG_LIMIT_ENABLE, (CFG_DAT_W'($urandom) & ~CFG_DAT_W'(1)) | CFG_DAT_W'(en));
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic void add_byte(logic [7:0] c);
        msg_q.push_back({MODE_BYTE, c});
    endfunction

    function automatic void add_size_line(logic [31:0] sz, int zeros);
        int top;
        repeat (zeros) add_byte(8'h30);
        top = 7;
        while (top > 0 && sz[top*4 +: 4] == 4'd0) top--;
        for (int i = top; i >= 0; i--) add_byte(hex_char(sz[i*4 +: 4]));
        add_byte(CHAR_CR);
        add_byte(CHAR_LF);
    endfunction

    function automatic void build_message();
        int n_chunks;
        int sz;
        int zeros;
        msg_q.delete();
        if ($urandom_range(0, 9) != 0) msg_q.push_back({MODE_RESTART, 8'($urandom)});
        if ($urandom_range(0, 19) == 0) begin
            // plain noise, biased toward the bytes the parser cares about
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 3))
                    0: add_byte(CHAR_CR);
                    1: add_byte(CHAR_LF);
                    2: add_byte(hex_char(4'($urandom)));
                    default: add_byte(8'($urandom));
                endcase
            end
            return;
        end
        if ($urandom_range(0, 14) == 0) begin
            // huge size: a few data bytes, then abandoned
            add_size_line($urandom_range(1, 15) << 28 | 32'($urandom_range(0, 32'h0FFF_FFFF)), 0);
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
            return;
        end
        if ($urandom_range(0, 14) == 0) begin
            // one digit too many for the size register
            add_byte(hex_char(4'($urandom_range(1, 15))));
            repeat (8) add_byte(hex_char(4'($urandom)));
            return;
        end
        n_chunks = $urandom_range(0, 3);
        repeat (n_chunks) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 17) : 0;
            add_size_line(32'(sz), zeros);
            repeat (sz) add_byte(8'($urandom));
            add_byte(CHAR_CR);
            add_byte(CHAR_LF);
        end
        add_size_line(32'd0, $urandom_range(0, 2));
        add_byte(CHAR_CR);
        add_byte(CHAR_LF);
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
        if ($urandom_range(0, 7) == 0) begin
            msg_q[$urandom_range(0, msg_q.size() - 1)][7:0] = 8'($urandom);
        end
        if ($urandom_range(0, 9) == 0) begin
            msg_q = msg_q[0:$urandom_range(0, msg_q.size() - 1)];
        end
    endfunction

    task automatic test_good_message();
        restart();
        send_text("2\r\n");
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_text("\r\n0\r\n\r\n");
        // ignored once done
        send_item(MODE_BYTE, 8'hFF);
    endtask

    task automatic test_size_line_errors();
        restart();
        send_text("1;");
        restart();
        send_text("\r");
        restart();
        send_text("1\n");
        restart();
        send_text("1\rX");
        restart();
        send_text("100000000\r\n");
    endtask

    task automatic test_trailer_errors();
        restart();
        send_text("1\r\nAB");
        restart();
        send_text("1\r\nA\rB");
        restart();
        send_text("0\r\nX");
    endtask

    task automatic test_body_limit();
        set_limit(32'd3, 1'b1);
        restart();
        send_text("3\r\nxyz\r\n1\r\n");
        set_limit(32'd0, 1'b1);
        restart();
        send_text("0\r\n\r\n");
        restart();
        send_text("1\r\n");
        set_limit(32'hFFFF_FFFF, 1'b1);
        restart();
        send_text("FFFFFFFF\r\nab");
    endtask

    task automatic test_random_traffic();
        logic [31:0] max_sel[6];
        logic        en_sel[6];
        int          target;
        max_sel = '{32'd0, 32'd0, 32'd24, 32'($urandom_range(8, 60)), 32'hFFFF_FFFF,
                    32'($urandom)};
        en_sel  = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
        for (int p = 0; p < 6; p++) begin
            set_limit(max_sel[p], en_sel[p]);
            target = sent + (TOTAL_ITEMS - sent) / (6 - p);
            if (p == 5) quiet = 1'b1;
            while (sent < target) begin
                gaps_on = !quiet && ($urandom_range(0, 3) != 0);
                build_message();
                foreach (msg_q[i]) send_item(msg_q[i][8], msg_q[i][7:0]);
            end
        end
    endtask

    // result side: random stall bursts and calm stretches
    initial begin : result_ready
        int stall;
        int calm;
        stall = 0;
        calm = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
                if (calm > 0) begin
                    calm--;
                end else if (!quiet) begin
                    case ($urandom_range(0, 15))
                        0, 1: stall = $urandom_range(1, 19);
                        2: calm = $urandom_range(20, 150);
                        default: ;
                    endcase
                end
            end
        end
    end

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_words
        t_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: word with nothing expected, actual %h", $time,
                         {out_ch.body_valid, out_ch.body_byte, out_ch.done_res,
                          out_ch.failed, out_ch.error_kind});
                errors++;
            end else begin
                want = decoded_q.pop_front();
                compare_field("body_valid", 8'(want.body_valid), 8'(out_ch.body_valid));
                compare_field("body_byte", want.body_byte, out_ch.body_byte);
                compare_field("done_res", 8'(want.done_res), 8'(out_ch.done_res));
                compare_field("failed", 8'(want.failed), 8'(out_ch.failed));
                compare_field("error_kind", 8'(want.error_kind), 8'(out_ch.error_kind));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.mode    <= MODE_BYTE;
        in_ch.byte_in <= 8'h00;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_MAX_BODY_SIZE;
        cfg_ch.data   <= '0;
        clear_decoder();
        lim_max = '0;
        lim_en  = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_good_message();
        test_size_line_errors();
        test_trailer_errors();
        test_body_limit();
        test_random_traffic();

        drain();
        repeat (5) @(posedge i_clk);
        if (errors == 0 && decoded_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
